// ===== hw/rtl/gps_pkg.sv =====
// Shared types and constants for the granular particle stress pipeline.
// Holds field widths, register index codes and the elaboration-time root table.
package gps_pkg;

   localparam int ALPHA_W   = 17;
   localparam int PSOLID_W  = 32;
   localparam int BETA_W    = 16;
   localparam int EPS_W     = 16;
   localparam int STRESS_W  = 48;
   localparam int LOG_STEPS = 24;
   localparam int IE_W      = 5;
   localparam int MAN_W     = 32;
   localparam int POW_W     = 33;
   localparam int TINT_W    = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [ALPHA_W-1:0]  ONE_Q16    = 17'd65536;
   localparam logic [STRESS_W-1:0] STRESS_MAX = '1;

   localparam logic [PSOLID_W-1:0] P_SOLID_RST      = 32'd327680;
   localparam logic [BETA_W-1:0]   BETA_EXP_RST     = 16'd12288;
   localparam logic [EPS_W-1:0]    EPS_FLOOR_RST    = 16'd1;
   localparam logic [ALPHA_W-1:0]  ALPHA_PACKED_RST = 17'd39322;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_P_SOLID      = 2'd0,
      CSR_BETA_EXP     = 2'd1,
      CSR_EPS_FLOOR    = 2'd2,
      CSR_ALPHA_PACKED = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [STRESS_W-1:0] stress;
      logic [STRESS_W-1:0] dstress;
      logic                stress_sat;
      logic                dstress_sat;
   } rsp_word_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem = v;
      res = '0;
      for (int i = 31; i >= 0; i--) begin
         bitv = 64'd1 << (2 * i);
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // root k = 2^(-2^-k) in Q0.32, floor square root chain from one half
   function automatic logic [31:0] exp_root(input int k);
      logic [63:0] root;
      root = 64'd1 << 31;
      for (int j = 1; j <= k; j++) begin
         root = isqrt64(root << 32);
      end
      return root[31:0];
   endfunction

endpackage

// ===== hw/rtl/gps_front.sv =====
// Input register, clamps, denominator select and mantissa normalize.
// Uses gps_pkg; feeds the divider and log2 stages.
module gps_front #(
   parameter int DEN_FRAC_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [gps_pkg::ALPHA_W-1:0]  in_alpha,
   input  logic [gps_pkg::EPS_W-1:0]    eps_floor,
   input  logic [gps_pkg::ALPHA_W-1:0]  alpha_packed,
   output logic                         out_valid,
   output logic [gps_pkg::ALPHA_W-1:0]  out_alpha,
   output logic                         out_zero,
   output logic [DEN_FRAC_BITS:0]       out_den,
   output logic [gps_pkg::MAN_W-1:0]    out_man,
   output logic [gps_pkg::IE_W-1:0]     out_ie
);
   import gps_pkg::*;

   localparam int DW = DEN_FRAC_BITS + 1;

   logic               valid0_ff;
   logic [ALPHA_W-1:0] alpha0_ff;

   logic [ALPHA_W-1:0] a_c;
   logic [ALPHA_W-1:0] ap_c;
   logic [ALPHA_W-1:0] diff;
   logic [DW-1:0]      d1;
   logic [DW-1:0]      d2;
   logic [32:0]        eprod;
   logic [DW-1:0]      den_in;
   logic [IE_W-1:0]    msb;
   logic [IE_W-1:0]    shamt;
   logic [MAN_W-1:0]   man_in;
   logic [IE_W-1:0]    ie_in;

   logic               valid1_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic               zero_ff;
   logic [DW-1:0]      den_ff;
   logic [MAN_W-1:0]   man_ff;
   logic [IE_W-1:0]    ie_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else if (en) begin
         valid0_ff <= in_valid;
         valid1_ff <= valid0_ff;
      end
   end

   always_comb begin
      a_c   = (alpha0_ff > ONE_Q16) ? ONE_Q16 : alpha0_ff;
      ap_c  = (alpha_packed > ONE_Q16) ? ONE_Q16 : alpha_packed;
      diff  = ap_c - a_c;
      d1    = (ap_c > a_c) ? (DW'(diff) << (DEN_FRAC_BITS - 16)) : '0;
      eprod = eps_floor * (ONE_Q16 - a_c);
      d2    = DW'(eprod >> (32 - DEN_FRAC_BITS));
      den_in = DW'(1);
      if (d1 > den_in) begin
         den_in = d1;
      end
      if (d2 > den_in) begin
         den_in = d2;
      end
      msb = '0;
      for (int i = 0; i < ALPHA_W; i++) begin
         if (a_c[i]) begin
            msb = IE_W'(i);
         end
      end
      shamt  = 5'd31 - msb;
      man_in = MAN_W'(a_c) << shamt;
      ie_in  = 5'd16 - msb;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         alpha0_ff <= in_alpha;
         alpha_ff  <= a_c;
         zero_ff   <= (a_c == '0);
         den_ff    <= den_in;
         man_ff    <= man_in;
         ie_ff     <= ie_in;
      end
   end

   assign out_valid = valid1_ff;
   assign out_alpha = alpha_ff;
   assign out_zero  = zero_ff;
   assign out_den   = den_ff;
   assign out_man   = man_ff;
   assign out_ie    = ie_ff;

endmodule

// ===== hw/rtl/gps_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; carries a side word alongside each division.
module gps_div #(
   parameter int NW = 48,
   parameter int DW = 33,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic          valid_ff [0:NW-1];
   logic [DW-1:0] rem_ff   [0:NW-1];
   logic [NW-1:0] nq_ff    [0:NW-1];
   logic [DW-1:0] den_ff   [0:NW-1];
   logic [SW-1:0] side_ff  [0:NW-1];

   for (genvar s = 0; s < NW; s++) begin : g_step
      logic          cur_valid;
      logic [DW-1:0] cur_rem;
      logic [NW-1:0] cur_nq;
      logic [DW-1:0] cur_den;
      logic [SW-1:0] cur_side;
      logic [DW:0]   cand;
      logic          take;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] nq_in;

      if (s == 0) begin : g_head
         assign cur_valid = in_valid;
         assign cur_rem   = in_rem;
         assign cur_nq    = in_num;
         assign cur_den   = in_den;
         assign cur_side  = in_side;
      end else begin : g_body
         assign cur_valid = valid_ff[s-1];
         assign cur_rem   = rem_ff[s-1];
         assign cur_nq    = nq_ff[s-1];
         assign cur_den   = den_ff[s-1];
         assign cur_side  = side_ff[s-1];
      end

      always_comb begin
         cand   = {cur_rem, cur_nq[NW-1]};
         take   = (cand >= {1'b0, cur_den});
         rem_in = take ? DW'(cand - {1'b0, cur_den}) : cand[DW-1:0];
         nq_in  = {cur_nq[NW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            nq_ff[s]   <= nq_in;
            den_ff[s]  <= cur_den;
            side_ff[s] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quo   = nq_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

// ===== hw/rtl/gps_log.sv =====
// Bit-serial log2 fraction: one mantissa squaring per stage.
// Uses gps_pkg for the step count and mantissa width.
module gps_log #(
   parameter int SW = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [gps_pkg::MAN_W-1:0]     in_man,
   input  logic [SW-1:0]                 in_side,
   output logic                          out_valid,
   output logic [gps_pkg::LOG_STEPS-1:0] out_frac,
   output logic [SW-1:0]                 out_side
);
   import gps_pkg::*;

   logic                 valid_ff [0:LOG_STEPS-1];
   logic [MAN_W-1:0]     man_ff   [0:LOG_STEPS-1];
   logic [LOG_STEPS-1:0] frac_ff  [0:LOG_STEPS-1];
   logic [SW-1:0]        side_ff  [0:LOG_STEPS-1];

   for (genvar s = 0; s < LOG_STEPS; s++) begin : g_step
      logic                 cur_valid;
      logic [MAN_W-1:0]     cur_man;
      logic [LOG_STEPS-1:0] cur_frac;
      logic [SW-1:0]        cur_side;
      logic [2*MAN_W-1:0]   sq;
      logic [MAN_W:0]       sh;
      logic [MAN_W-1:0]     man_in;
      logic [LOG_STEPS-1:0] frac_in;

      if (s == 0) begin : g_head
         assign cur_valid = in_valid;
         assign cur_man   = in_man;
         assign cur_frac  = '0;
         assign cur_side  = in_side;
      end else begin : g_body
         assign cur_valid = valid_ff[s-1];
         assign cur_man   = man_ff[s-1];
         assign cur_frac  = frac_ff[s-1];
         assign cur_side  = side_ff[s-1];
      end

      always_comb begin
         sq      = cur_man * cur_man;
         sh      = sq[2*MAN_W-1:MAN_W-1];
         man_in  = sh[MAN_W] ? sh[MAN_W:1] : sh[MAN_W-1:0];
         frac_in = {cur_frac[LOG_STEPS-2:0], sh[MAN_W]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            man_ff[s]  <= man_in;
            frac_ff[s] <= frac_in;
            side_ff[s] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[LOG_STEPS-1];
   assign out_frac  = frac_ff[LOG_STEPS-1];
   assign out_side  = side_ff[LOG_STEPS-1];

endmodule

// ===== hw/rtl/gps_exp.sv =====
// Exponent scale, square-root-chain exp2 and final shift to alpha^beta.
// Uses gps_pkg for widths and the root constants.
module gps_exp #(
   parameter int SW = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [gps_pkg::IE_W-1:0]      in_ie,
   input  logic [gps_pkg::LOG_STEPS-1:0] in_frac,
   input  logic                          in_zero,
   input  logic [gps_pkg::BETA_W-1:0]    beta_exp,
   input  logic [SW-1:0]                 in_side,
   output logic                          out_valid,
   output logic [gps_pkg::POW_W-1:0]     out_pow,
   output logic                          out_zero,
   output logic [SW-1:0]                 out_side
);
   import gps_pkg::*;

   localparam int NEG_W = IE_W + LOG_STEPS;
   localparam int TW    = TINT_W + LOG_STEPS;

   logic [NEG_W-1:0]        neg;
   logic [BETA_W+NEG_W-1:0] tprod;

   logic                t_valid_ff;
   logic [TW-1:0]       t_ff;
   logic                t_zero_ff;
   logic [SW-1:0]       t_side_ff;

   logic                 valid_ff [0:LOG_STEPS-1];
   logic [POW_W-1:0]     r_ff     [0:LOG_STEPS-1];
   logic [LOG_STEPS-1:0] f_ff     [0:LOG_STEPS-1];
   logic [TINT_W-1:0]    n_ff     [0:LOG_STEPS-1];
   logic                 zero_ff  [0:LOG_STEPS-1];
   logic [SW-1:0]        side_ff  [0:LOG_STEPS-1];

   logic [POW_W-1:0]    pow_in;
   logic                p_valid_ff;
   logic [POW_W-1:0]    pow_ff;
   logic                p_zero_ff;
   logic [SW-1:0]       p_side_ff;

   always_comb begin
      neg   = {in_ie, {LOG_STEPS{1'b0}}} - NEG_W'(in_frac);
      tprod = beta_exp * neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else if (en) begin
         t_valid_ff <= in_valid;
         p_valid_ff <= valid_ff[LOG_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff      <= tprod[BETA_W+NEG_W-1:12];
         t_zero_ff <= in_zero;
         t_side_ff <= in_side;
      end
   end

   for (genvar s = 0; s < LOG_STEPS; s++) begin : g_step
      localparam logic [31:0] ROOT = exp_root(s + 1);

      logic                 cur_valid;
      logic [POW_W-1:0]     cur_r;
      logic [LOG_STEPS-1:0] cur_f;
      logic [TINT_W-1:0]    cur_n;
      logic                 cur_zero;
      logic [SW-1:0]        cur_side;
      logic [POW_W+31:0]    prod;
      logic [POW_W-1:0]     r_in;

      if (s == 0) begin : g_head
         assign cur_valid = t_valid_ff;
         assign cur_r     = POW_W'(1) << 32;
         assign cur_f     = t_ff[LOG_STEPS-1:0];
         assign cur_n     = t_ff[TW-1:LOG_STEPS];
         assign cur_zero  = t_zero_ff;
         assign cur_side  = t_side_ff;
      end else begin : g_body
         assign cur_valid = valid_ff[s-1];
         assign cur_r     = r_ff[s-1];
         assign cur_f     = f_ff[s-1];
         assign cur_n     = n_ff[s-1];
         assign cur_zero  = zero_ff[s-1];
         assign cur_side  = side_ff[s-1];
      end

      always_comb begin
         prod = cur_r * ROOT;
         r_in = cur_f[LOG_STEPS-1] ? prod[POW_W+31:32] : cur_r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]    <= r_in;
            f_ff[s]    <= {cur_f[LOG_STEPS-2:0], 1'b0};
            n_ff[s]    <= cur_n;
            zero_ff[s] <= cur_zero;
            side_ff[s] <= cur_side;
         end
      end
   end

   always_comb begin
      if (zero_ff[LOG_STEPS-1]) begin
         pow_in = (beta_exp == '0) ? (POW_W'(1) << 32) : '0;
      end else if (n_ff[LOG_STEPS-1] >= TINT_W'(64)) begin
         pow_in = '0;
      end else begin
         pow_in = r_ff[LOG_STEPS-1] >> n_ff[LOG_STEPS-1][5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pow_ff    <= pow_in;
         p_zero_ff <= zero_ff[LOG_STEPS-1];
         p_side_ff <= side_ff[LOG_STEPS-1];
      end
   end

   assign out_valid = p_valid_ff;
   assign out_pow   = pow_ff;
   assign out_zero  = p_zero_ff;
   assign out_side  = p_side_ff;

endmodule

// ===== hw/rtl/granular_particle_stress.sv =====
// Granular particle stress: one alpha word in, one stress/derivative word out per cycle.
// Its depth is set by the three divider chains that resolve one quotient bit per stage
// plus the 24-stage log2 unit and exp2 root chain; the pipeline takes a word every cycle
// and holds only when the output skid stage is full.
// Uses gps_pkg, gps_front, gps_div, gps_log and gps_exp.
module granular_particle_stress #(
   parameter int DEN_FRAC_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gps_pkg::ALPHA_W-1:0]     req_alpha_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gps_pkg::STRESS_W-1:0]    rsp_stress_out,
   output logic [gps_pkg::STRESS_W-1:0]    rsp_dstress_out,
   output logic                            rsp_stress_sat,
   output logic                            rsp_dstress_sat,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  gps_pkg::csr_index_type          csr_index,
   input  logic [gps_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gps_pkg::*;

   localparam int DL  = DEN_FRAC_BITS + 1;
   localparam int Q1W = 36;
   localparam int Q2W = DEN_FRAC_BITS + 17;
   localparam int GW  = ((Q2W > Q1W) ? Q2W : Q1W) + 1;
   localparam int GHW = GW - 24;
   localparam int MW  = ((GW > 48) ? GW : 48) + 1;
   localparam int PW  = 48 + GW;
   localparam int QW  = 33;
   localparam int S1  = 1 + DL + MAN_W + IE_W;
   localparam int S2  = S1 + Q1W;
   localparam int SL  = 1 + DL + GW + IE_W;
   localparam int SE  = DL + GW;
   localparam int ST  = 2 + GW;

   logic [PSOLID_W-1:0] p_solid_ff;
   logic [BETA_W-1:0]   beta_exp_ff;
   logic [EPS_W-1:0]    eps_floor_ff;
   logic [ALPHA_W-1:0]  alpha_packed_ff;

   logic en;

   logic               fr_valid;
   logic [ALPHA_W-1:0] fr_alpha;
   logic               fr_zero;
   logic [DL-1:0]      fr_den;
   logic [MAN_W-1:0]   fr_man;
   logic [IE_W-1:0]    fr_ie;

   logic               g1_valid;
   logic [Q1W-1:0]     g1_quo;
   logic [S1-1:0]      g1_side;
   logic               g1_zero;
   logic [DL-1:0]      g1_den;
   logic [MAN_W-1:0]   g1_man;
   logic [IE_W-1:0]    g1_ie;

   logic               g2_valid;
   logic [Q2W-1:0]     g2_quo;
   logic [S2-1:0]      g2_side;
   logic               g2_zero;
   logic [DL-1:0]      g2_den;
   logic [MAN_W-1:0]   g2_man;
   logic [IE_W-1:0]    g2_ie;
   logic [Q1W-1:0]     g2_q1;
   logic [GW-1:0]      g2_g;

   logic                 lg_valid;
   logic [LOG_STEPS-1:0] lg_frac;
   logic [SL-1:0]        lg_side;
   logic                 lg_zero;
   logic [DL-1:0]        lg_den;
   logic [GW-1:0]        lg_g;
   logic [IE_W-1:0]      lg_ie;

   logic             ex_valid;
   logic [POW_W-1:0] ex_pow;
   logic             ex_zero;
   logic [SE-1:0]    ex_side;
   logic [DL-1:0]    ex_den;
   logic [GW-1:0]    ex_g;

   logic [PSOLID_W+POW_W-1:0] num_prod;

   logic          n1_valid_ff;
   logic [63:0]   n1_num_ff;
   logic [QW-1:0] n1_q_ff;
   logic          n1_zero_ff;
   logic [GW-1:0] n1_g_ff;

   logic          ov_in;
   logic          n2_valid_ff;
   logic          n2_ov_ff;
   logic [QW-1:0] n2_rem_ff;
   logic [47:0]   n2_lo_ff;
   logic [QW-1:0] n2_q_ff;
   logic          n2_zero_ff;
   logic [GW-1:0] n2_g_ff;

   logic          tv_valid;
   logic [47:0]   tv_tau;
   logic [ST-1:0] tv_side;
   logic          tv_zero;
   logic          tv_ov;
   logic [GW-1:0] tv_g;

   logic          f1_valid_ff;
   logic [47:0]   f1_ll_ff;
   logic [GW-1:0] f1_lh_ff;
   logic [47:0]   f1_hl_ff;
   logic [GW-1:0] f1_hh_ff;
   logic [47:0]   f1_tau_ff;
   logic          f1_zero_ff;
   logic          f1_ov_ff;

   logic          f2_valid_ff;
   logic [47:0]   f2_ll_ff;
   logic [MW-1:0] f2_mid_ff;
   logic [GW-1:0] f2_hh_ff;
   logic [47:0]   f2_tau_ff;
   logic          f2_zero_ff;
   logic          f2_ov_ff;

   logic [PW-1:0] full;
   rsp_word_type  res;

   logic         rsp_valid_ff;
   logic         skid_valid_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type skid_word_ff;
   logic         take;
   logic         arrive;
   logic         rsp_valid_in;
   logic         skid_valid_in;
   logic         rsp_load_pipe;
   logic         rsp_load_skid;
   logic         skid_load;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_solid_ff      <= P_SOLID_RST;
         beta_exp_ff     <= BETA_EXP_RST;
         eps_floor_ff    <= EPS_FLOOR_RST;
         alpha_packed_ff <= ALPHA_PACKED_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_P_SOLID:      p_solid_ff      <= csr_data[PSOLID_W-1:0];
            CSR_BETA_EXP:     beta_exp_ff     <= csr_data[BETA_W-1:0];
            CSR_EPS_FLOOR:    eps_floor_ff    <= csr_data[EPS_W-1:0];
            CSR_ALPHA_PACKED: alpha_packed_ff <= csr_data[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // advance the whole pipeline unless the skid stage holds a word
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   gps_front #(
      .DEN_FRAC_BITS (DEN_FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .in_alpha     (req_alpha_in),
      .eps_floor    (eps_floor_ff),
      .alpha_packed (alpha_packed_ff),
      .out_valid    (fr_valid),
      .out_alpha    (fr_alpha),
      .out_zero     (fr_zero),
      .out_den      (fr_den),
      .out_man      (fr_man),
      .out_ie       (fr_ie)
   );

   gps_div #(
      .NW (Q1W),
      .DW (ALPHA_W),
      .SW (S1)
   ) u_div_beta (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_num    ({beta_exp_ff, 20'd0}),
      .in_rem    ('0),
      .in_den    (fr_alpha),
      .in_side   ({fr_zero, fr_den, fr_man, fr_ie}),
      .out_valid (g1_valid),
      .out_quo   (g1_quo),
      .out_side  (g1_side)
   );

   assign {g1_zero, g1_den, g1_man, g1_ie} = g1_side;

   gps_div #(
      .NW (Q2W),
      .DW (DL),
      .SW (S2)
   ) u_div_den (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g1_valid),
      .in_num    (Q2W'(1) << (DEN_FRAC_BITS + 16)),
      .in_rem    ('0),
      .in_den    (g1_den),
      .in_side   ({g1_zero, g1_den, g1_man, g1_ie, g1_quo}),
      .out_valid (g2_valid),
      .out_quo   (g2_quo),
      .out_side  (g2_side)
   );

   assign {g2_zero, g2_den, g2_man, g2_ie, g2_q1} = g2_side;
   assign g2_g = GW'(g2_q1) + GW'(g2_quo);

   gps_log #(
      .SW (SL)
   ) u_log (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g2_valid),
      .in_man    (g2_man),
      .in_side   ({g2_zero, g2_den, g2_g, g2_ie}),
      .out_valid (lg_valid),
      .out_frac  (lg_frac),
      .out_side  (lg_side)
   );

   assign {lg_zero, lg_den, lg_g, lg_ie} = lg_side;

   gps_exp #(
      .SW (SE)
   ) u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (lg_valid),
      .in_ie     (lg_ie),
      .in_frac   (lg_frac),
      .in_zero   (lg_zero),
      .beta_exp  (beta_exp_ff),
      .in_side   ({lg_den, lg_g}),
      .out_valid (ex_valid),
      .out_pow   (ex_pow),
      .out_zero  (ex_zero),
      .out_side  (ex_side)
   );

   assign {ex_den, ex_g} = ex_side;
   assign num_prod = p_solid_ff * ex_pow;
   assign ov_in    = (QW'(n1_num_ff[63:48]) >= n1_q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_valid_ff <= 1'b0;
         n2_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         n1_valid_ff <= ex_valid;
         n2_valid_ff <= n1_valid_ff;
         f1_valid_ff <= tv_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_num_ff  <= num_prod[63:0];
         n1_q_ff    <= QW'(ex_den) << (32 - DEN_FRAC_BITS);
         n1_zero_ff <= ex_zero;
         n1_g_ff    <= ex_g;
         n2_ov_ff   <= ov_in;
         n2_rem_ff  <= ov_in ? '0 : QW'(n1_num_ff[63:48]);
         n2_lo_ff   <= n1_num_ff[47:0];
         n2_q_ff    <= n1_q_ff;
         n2_zero_ff <= n1_zero_ff;
         n2_g_ff    <= n1_g_ff;
      end
   end

   gps_div #(
      .NW (48),
      .DW (QW),
      .SW (ST)
   ) u_div_tau (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (n2_valid_ff),
      .in_num    (n2_lo_ff),
      .in_rem    (n2_rem_ff),
      .in_den    (n2_q_ff),
      .in_side   ({n2_zero_ff, n2_ov_ff, n2_g_ff}),
      .out_valid (tv_valid),
      .out_quo   (tv_tau),
      .out_side  (tv_side)
   );

   assign {tv_zero, tv_ov, tv_g} = tv_side;

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ll_ff   <= tv_tau[23:0] * tv_g[23:0];
         f1_lh_ff   <= tv_tau[23:0] * tv_g[GW-1:24];
         f1_hl_ff   <= tv_tau[47:24] * tv_g[23:0];
         f1_hh_ff   <= tv_tau[47:24] * tv_g[GW-1:24];
         f1_tau_ff  <= tv_tau;
         f1_zero_ff <= tv_zero;
         f1_ov_ff   <= tv_ov;
         f2_ll_ff   <= f1_ll_ff;
         f2_mid_ff  <= MW'(f1_lh_ff) + MW'(f1_hl_ff);
         f2_hh_ff   <= f1_hh_ff;
         f2_tau_ff  <= f1_tau_ff;
         f2_zero_ff <= f1_zero_ff;
         f2_ov_ff   <= f1_ov_ff;
      end
   end

   always_comb begin
      full = PW'(f2_ll_ff) + (PW'(f2_mid_ff) << 24) + (PW'(f2_hh_ff) << 48);
      res.stress_sat  = f2_ov_ff;
      res.stress      = f2_ov_ff ? STRESS_MAX : f2_tau_ff;
      res.dstress_sat = f2_zero_ff || f2_ov_ff || (full[PW-1:64] != '0);
      res.dstress     = res.dstress_sat ? STRESS_MAX : full[63:16];
   end

   // output register with one skid word behind it
   always_comb begin
      take          = rsp_valid_ff && !rsp_stall;
      arrive        = en && f2_valid_ff;
      rsp_load_pipe = 1'b0;
      rsp_load_skid = 1'b0;
      skid_load     = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_load_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (!rsp_valid_ff || take) begin
            rsp_load_pipe = 1'b1;
            rsp_valid_in  = 1'b1;
         end else begin
            skid_load     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load_pipe) begin
         rsp_word_ff <= res;
      end else if (rsp_load_skid) begin
         rsp_word_ff <= skid_word_ff;
      end
      if (skid_load) begin
         skid_word_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_stress_out  = rsp_word_ff.stress;
   assign rsp_dstress_out = rsp_word_ff.dstress;
   assign rsp_stress_sat  = rsp_word_ff.stress_sat;
   assign rsp_dstress_sat = rsp_word_ff.dstress_sat;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held with empty output register");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled while output register was free");

   a_stress_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.stress_sat |->
         rsp_word_ff.dstress_sat && rsp_word_ff.stress == STRESS_MAX)
      else $error("stress saturation without saturated outputs");

   a_dstress_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.dstress_sat |-> rsp_word_ff.dstress == STRESS_MAX)
      else $error("derivative flag set without maximum value");

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for granular_particle_stress: stress and derivative per alpha word.
// Predicts untyped results in fixed point, checks all; uses gps_pkg and the RTL top.
module tb;
   import gps_pkg::*;

   localparam int DFRAC = 24;
   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      logic [ALPHA_W-1:0] alpha;
      bit                 typed;
      rsp_word_type       want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [ALPHA_W-1:0]    req_alpha_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STRESS_W-1:0]   rsp_stress_out;
   logic [STRESS_W-1:0]   rsp_dstress_out;
   logic                  rsp_stress_sat;
   logic                  rsp_dstress_sat;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   logic [PSOLID_W-1:0] cfg_psolid;
   logic [BETA_W-1:0]   cfg_beta;
   logic [EPS_W-1:0]    cfg_eps;
   logic [ALPHA_W-1:0]  cfg_packed;

   rsp_word_type stress_q[$];
   int errors;
   int quiet_cycles;
   int burst_left;
   int stall_mode;
   int stall_age;

   granular_particle_stress i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] trial;
      res = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = res | (64'd1 << i);
         if (trial * trial <= v) res = trial;
      end
      return res;
   endfunction

   // alpha^beta in Q.32 through log2 by squaring and an exp2 root chain
   function automatic logic [63:0] alpha_pow(input logic [63:0] a, input logic [63:0] beta);
      logic [63:0] m, frac, neg, t, n, f, r, root;
      int e;
      frac = '0;
      e = 16;
      if (a < 64'd65536) begin
         e = 15;
         while (a[e] == 1'b0) e--;
      end
      m = (e == 16) ? (64'd1 << 31) : (a << (31 - e));
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac[23 - i] = 1'b1;
         end
      end
      neg = (e == 16) ? 64'd0 : ((64'(16 - e) << 24) - frac);
      t = (beta * neg) >> 12;
      n = t >> 24;
      f = t & 64'hFF_FFFF;
      r = 64'd1 << 32;
      root = 64'd1 << 31;
      for (int i = 1; i <= 24; i++) begin
         root = floor_sqrt(root << 32);
         if (f[24 - i]) r = (r * root) >> 32;
      end
      return (n >= 64) ? 64'd0 : (r >> n);
   endfunction

   function automatic rsp_word_type stress_of(input logic [ALPHA_W-1:0] ain);
      logic [63:0] a, ap, d, d1, d2, pw, num, q, tau, g;
      logic [127:0] prod;
      rsp_word_type w;
      a = 64'(ain);
      ap = 64'(cfg_packed);
      if (a > 64'd65536) a = 64'd65536;
      if (ap > 64'd65536) ap = 64'd65536;
      d1 = (ap > a) ? ((ap - a) << (DFRAC - 16)) : 64'd0;
      d2 = (64'(cfg_eps) * (64'd65536 - a)) >> (32 - DFRAC);
      d = 64'd1;
      if (d1 > d) d = d1;
      if (d2 > d) d = d2;
      if (a == 0) pw = (cfg_beta == 0) ? (64'd1 << 32) : 64'd0;
      else pw = alpha_pow(a, 64'(cfg_beta));
      num = 64'(cfg_psolid) * pw;
      q = d << (32 - DFRAC);
      tau = num / q;
      w.stress_sat = 1'b0;
      w.dstress_sat = 1'b0;
      if (tau > 64'(STRESS_MAX)) begin
         tau = 64'(STRESS_MAX);
         w.stress_sat = 1'b1;
      end
      w.stress = tau[STRESS_W-1:0];
      if (a == 0 || w.stress_sat) begin
         w.dstress = STRESS_MAX;
         w.dstress_sat = 1'b1;
      end else begin
         g = ((64'(cfg_beta) << 20) / a) + ((64'd1 << (DFRAC + 16)) / d);
         prod = 128'(tau) * 128'(g);
         if (prod > 128'(64'hFFFF_FFFF_FFFF_FFFF)) begin
            w.dstress = STRESS_MAX;
            w.dstress_sat = 1'b1;
         end else begin
            w.dstress = prod[STRESS_W+15:16];
         end
      end
      return w;
   endfunction

   task automatic send_word(input logic [ALPHA_W-1:0] a, input bit typed,
                            input rsp_word_type want);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_alpha_in <= a;
      do @(posedge clock); while (req_stall);
      stress_q.push_back(typed ? want : stress_of(a));
      burst_left--;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (stress_q.size() != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_P_SOLID:      cfg_psolid = value[PSOLID_W-1:0];
         CSR_BETA_EXP:     cfg_beta = value[BETA_W-1:0];
         CSR_EPS_FLOOR:    cfg_eps = value[EPS_W-1:0];
         CSR_ALPHA_PACKED: cfg_packed = value[ALPHA_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [ALPHA_W-1:0] pick_alpha();
      int sel;
      int near;
      sel = $urandom_range(0, 9);
      near = int'(cfg_packed > ONE_Q16 ? ONE_Q16 : cfg_packed) + $urandom_range(0, 32) - 16;
      if (near < 0) near = 0;
      if (near > 65536) near = 65536;
      case (sel)
         0: return '0;
         1: return ONE_Q16;
         2: return ALPHA_W'($urandom_range(65537, 131071));
         3: return ALPHA_W'(near);
         4: return ALPHA_W'($urandom_range(1, 64));
         default: return ALPHA_W'($urandom_range(0, 65536));
      endcase
   endfunction

   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_age <= $urandom_range(20, 150);
      end else begin
         stall_age <= stall_age - 1;
      end
      case (stall_mode)
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stress_q.size() == 0) begin
            $display("%0t: unexpected word stress=%h dstress=%h", $time,
                     rsp_stress_out, rsp_dstress_out);
            errors++;
         end else begin
            want = stress_q.pop_front();
            if (rsp_stress_out !== want.stress) begin
               $display("%0t: stress expected %h actual %h", $time, want.stress,
                        rsp_stress_out);
               errors++;
            end
            if (rsp_dstress_out !== want.dstress) begin
               $display("%0t: dstress expected %h actual %h", $time, want.dstress,
                        rsp_dstress_out);
               errors++;
            end
            if (rsp_stress_sat !== want.stress_sat) begin
               $display("%0t: stress_sat expected %b actual %b", $time, want.stress_sat,
                        rsp_stress_sat);
               errors++;
            end
            if (rsp_dstress_sat !== want.dstress_sat) begin
               $display("%0t: dstress_sat expected %b actual %b", $time, want.dstress_sat,
                        rsp_dstress_sat);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** granular_particle_stress: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row_type rows[$];
      rsp_word_type at_full;
      rsp_word_type at_zero;
      logic [31:0] ps, bt, ep, pk;
      errors = 0;
      quiet_cycles = 0;
      burst_left = 0;
      stall_mode = 0;
      stall_age = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_alpha_in <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_P_SOLID;
      csr_data <= '0;
      cfg_psolid = P_SOLID_RST;
      cfg_beta = BETA_EXP_RST;
      cfg_eps = EPS_FLOOR_RST;
      cfg_packed = ALPHA_PACKED_RST;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      at_zero = '{stress: '0, dstress: STRESS_MAX, stress_sat: 1'b0, dstress_sat: 1'b1};
      at_full = '{stress: 48'd5 << 40, dstress: STRESS_MAX, stress_sat: 1'b0,
                  dstress_sat: 1'b1};
      rows = '{
         '{17'd0,      1'b1, at_zero},
         '{17'd65536,  1'b1, at_full},
         '{17'd131071, 1'b1, at_full},
         '{17'd86357,  1'b1, at_full},
         '{17'd1,      1'b0, at_zero},
         '{17'd2,      1'b0, at_zero},
         '{17'd4095,   1'b0, at_zero},
         '{17'd32768,  1'b0, at_zero},
         '{17'd39321,  1'b0, at_zero},
         '{17'd39322,  1'b0, at_zero},
         '{17'd39323,  1'b0, at_zero},
         '{17'd43690,  1'b0, at_zero},
         '{17'd65535,  1'b0, at_zero}
      };
      foreach (rows[i]) send_word(rows[i].alpha, rows[i].typed, rows[i].want);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         ps = $urandom();
         bt = $urandom();
         ep = $urandom();
         pk = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 65536);
         case (ph)
            0: begin ps = '1; bt = 32'hFFFF; ep = 32'hFFFF; pk = 32'h1FFFF; end
            1: begin ps = '0; bt = '0; ep = '0; pk = '0; end
            2: begin ps = '1; bt = '0; ep = '0; pk = 32'h10000; end
            3: begin ps = 32'h0000_0001; bt = 32'h0000_0FFF; ep = 32'hFFFF; end
            default: ;
         endcase
         write_reg(CSR_P_SOLID, ps);
         write_reg(CSR_BETA_EXP, bt);
         write_reg(CSR_EPS_FLOOR, ep);
         write_reg(CSR_ALPHA_PACKED, pk);
         csr_valid <= 1'b0;
         for (int k = 0; k < 48; k++) begin
            send_word(pick_alpha(), 1'b0, at_zero);
            if (k == 24 && ph == 5) drain();
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (errors == 0 && stress_q.size() == 0) begin
         $display("** granular_particle_stress: PASSED **");
      end else begin
         $display("** granular_particle_stress: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/gps_pkg.sv
hw/rtl/gps_front.sv
hw/rtl/gps_div.sv
hw/rtl/gps_log.sv
hw/rtl/gps_exp.sv
hw/rtl/granular_particle_stress.sv
sim/tb.sv
